### rtl/bsc_pkg.sv
// Shared types, constants and the reciprocal table of the B-spline curve evaluator.
`timescale 1ns / 1ps
`default_nettype none
package bsc_pkg;

	localparam int T_W       = 17;
	localparam int COORD_W   = 32;
	localparam int BASIS_W   = 17;
	localparam int DEN_W     = 4;
	localparam int RECIP_W   = 25;
	localparam int RECIP_SH  = 24;
	localparam int X_W       = 20;
	localparam int Q_W       = 18;
	localparam int REM_W     = 22;
	localparam int ACC_W     = 50;
	localparam int DIM_W     = 2;
	localparam int ADDR_W    = 4;

	localparam logic [T_W-1:0]     ONE_Q16 = 17'd65536;

	localparam logic [1:0] REG_DEGREE      = 2'd0;
	localparam logic [1:0] REG_POINT_COUNT = 2'd1;
	localparam logic [1:0] REG_POINT_DIM   = 2'd2;

	localparam logic [2:0] RST_DEGREE      = 3'd3;
	localparam logic [6:0] RST_POINT_COUNT = 7'd4;
	localparam logic [2:0] RST_POINT_DIM   = 3'd3;

	typedef struct packed {
		logic [2:0] degree;
		logic [6:0] point_count;
		logic [2:0] point_dim;
	} cfg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SETUP,
		S_KNOT,
		S_BMUL,
		S_BDIV,
		S_BFIX,
		S_BTAIL,
		S_ARUN,
		S_AW1,
		S_AW2,
		S_AOUT,
		S_EOUT
	} state_t;

	typedef struct packed {
		logic load_wr;
		logic eval_start;
		logic setup;
		logic knot;
		logic bas_mul;
		logic bas_div;
		logic bas_fix;
		logic bas_tail;
		logic acc_issue;
		logic out_load;
		logic out_err;
	} cmd_t;

	typedef struct packed {
		logic err;
		logic deg_zero;
		logic r_last;
		logic j_last;
		logic acc_last;
		logic d_last;
		logic out_free;
	} st_t;

	// floor(2^24 / den) for the knot distances that can occur
	function automatic logic [RECIP_W-1:0] recip(input logic [DEN_W-1:0] den);
		logic [RECIP_W-1:0] r;
		case (den)
			4'd1:    r = 25'd16777216;
			4'd2:    r = 25'd8388608;
			4'd3:    r = 25'd5592405;
			4'd4:    r = 25'd4194304;
			4'd5:    r = 25'd3355443;
			4'd6:    r = 25'd2796202;
			4'd7:    r = 25'd2396745;
			4'd8:    r = 25'd2097152;
			4'd9:    r = 25'd1864135;
			4'd10:   r = 25'd1677721;
			4'd11:   r = 25'd1525201;
			4'd12:   r = 25'd1398101;
			4'd13:   r = 25'd1290555;
			4'd14:   r = 25'd1198372;
			4'd15:   r = 25'd1118481;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/bspline_curve_evaluator.sv
// Top level of the clamped uniform B-spline curve evaluator.
//
//  channel  direction  handshake               contents
//  s_*      in         s_tvalid / s_tready     load or evaluate request
//  m_*      out        m_tvalid / m_tready     one curve coordinate per result
//  p*       in/out     psel+penable (pready=1) degree, point_count, point_dim
//
// A load request writes one table entry.
// An evaluation of degree p and dimension n first runs the basis recursion one split
//   at a time through a multiplier and a reciprocal divider (multiply, divide, fix),
//   then forms each of the n weighted sums, reading one table entry per cycle
//   through the single read port.
// A bad configuration (point_count not above degree) answers with n zero coordinates with error status.
// Reset needs no clearing pass; table entries are undefined until loaded.
// The result register holds while m_tready is low; a new request is taken
// while the last result of the previous one still waits.
`timescale 1ns / 1ps
`default_nettype none
module bspline_curve_evaluator #(
	parameter int MAX_POINTS = 64,
	parameter int MAX_DEGREE = 7,
	parameter int MAX_DIM    = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// point_index[5:0], coord_index[7:6], coord_value[39:8], t_value[56:40]
	input  wire logic [63:0]                 s_tdata,
	// func[0]
	input  wire logic [0:0]                  s_tuser,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// out_coord_index[1:0], out_coord_value[33:2]
	output logic [39:0]                      m_tdata,
	// status[0]
	output logic [0:0]                       m_tuser,
	output logic                             m_tlast,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bsc_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready
);
	import bsc_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	st_t  st;

	logic [DIM_W-1:0]   out_idx;
	logic [COORD_W-1:0] out_value;
	logic               out_status;

	bsc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer decides, datapath does the arithmetic
	bsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_func  (s_tuser[0]),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	bsc_dp #(
		.MAX_POINTS (MAX_POINTS),
		.MAX_DEGREE (MAX_DEGREE),
		.MAX_DIM    (MAX_DIM)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.st         (st),
		.in_point   (s_tdata[5:0]),
		.in_coord   (s_tdata[7:6]),
		.in_value   (s_tdata[39:8]),
		.in_t       (s_tdata[56:40]),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_idx    (out_idx),
		.out_value  (out_value),
		.out_status (out_status),
		.out_last   (m_tlast)
	);

	// pack the result request
	assign m_tdata = {6'd0, out_value, out_idx};
	assign m_tuser = out_status;

endmodule
`default_nettype wire

### rtl/bsc_regs.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none
module bsc_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [bsc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready,
	output bsc_pkg::cfg_t                   cfg
);
	import bsc_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.degree      <= RST_DEGREE;
			cfg_q.point_count <= RST_POINT_COUNT;
			cfg_q.point_dim   <= RST_POINT_DIM;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_DEGREE:      cfg_q.degree      <= pwdata[2:0];
				REG_POINT_COUNT: cfg_q.point_count <= pwdata[6:0];
				REG_POINT_DIM:   cfg_q.point_dim   <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_DEGREE:      prdata = {29'd0, cfg_q.degree};
			REG_POINT_COUNT: prdata = {25'd0, cfg_q.point_count};
			REG_POINT_DIM:   prdata = {29'd0, cfg_q.point_dim};
			default:         prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

### rtl/bsc_ctrl.sv
// Sequencer of the evaluator: accepts requests and steps the datapath.
`timescale 1ns / 1ps
`default_nettype none
module bsc_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	input  wire logic         in_func,
	output logic              in_ready,
	input  bsc_pkg::st_t      st,
	output bsc_pkg::cmd_t     cmd
);
	import bsc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_valid && in_func) state_d = S_SETUP;
			S_SETUP: state_d = st.err ? S_EOUT : S_KNOT;
			S_KNOT:  state_d = st.deg_zero ? S_ARUN : S_BMUL;
			S_BMUL:  state_d = S_BDIV;
			S_BDIV:  state_d = S_BFIX;
			S_BFIX:  state_d = st.r_last ? S_BTAIL : S_BMUL;
			S_BTAIL: state_d = st.j_last ? S_ARUN : S_BMUL;
			S_ARUN:  if (st.acc_last) state_d = S_AW1;
			S_AW1:   state_d = S_AW2;
			S_AW2:   state_d = S_AOUT;
			S_AOUT:  if (st.out_free) state_d = st.d_last ? S_IDLE : S_ARUN;
			S_EOUT:  if (st.out_free && st.d_last) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready       = 1'b1;
				cmd.load_wr    = in_valid & ~in_func;
				cmd.eval_start = in_valid & in_func;
			end
			S_SETUP: cmd.setup     = 1'b1;
			S_KNOT:  cmd.knot      = 1'b1;
			S_BMUL:  cmd.bas_mul   = 1'b1;
			S_BDIV:  cmd.bas_div   = 1'b1;
			S_BFIX:  cmd.bas_fix   = 1'b1;
			S_BTAIL: cmd.bas_tail  = 1'b1;
			S_ARUN:  cmd.acc_issue = 1'b1;
			S_AOUT:  cmd.out_load  = st.out_free;
			S_EOUT:  cmd.out_err   = st.out_free;
			default: ;
		endcase
	end

	// a stalled output keeps the sequencer parked on the result
	a_out_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AOUT && !st.out_free) |=> (state_q == S_AOUT))
		else $error("output stall did not hold the sequencer");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ARUN && st.acc_last) |=> (state_q == S_AW1) ##1 (state_q == S_AW2)
		##1 (state_q == S_AOUT))
		else $error("accumulator drain sequence broken");

	a_err_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SETUP && st.err) |=> (state_q == S_EOUT))
		else $error("bad configuration did not take the error path");

endmodule
`default_nettype wire

### rtl/bsc_dp.sv
// Datapath: control table, basis recursion, weighted sum and output register.
`timescale 1ns / 1ps
`default_nettype none
module bsc_dp #(
	parameter int MAX_POINTS = 64,
	parameter int MAX_DEGREE = 7,
	parameter int MAX_DIM    = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  bsc_pkg::cfg_t                     cfg,
	input  bsc_pkg::cmd_t                     cmd,
	output bsc_pkg::st_t                      st,
	input  wire logic [5:0]                   in_point,
	input  wire logic [1:0]                   in_coord,
	input  wire logic [bsc_pkg::COORD_W-1:0]  in_value,
	input  wire logic [bsc_pkg::T_W-1:0]      in_t,
	input  wire logic                         out_ready,
	output logic                              out_valid,
	output logic [bsc_pkg::DIM_W-1:0]         out_idx,
	output logic [bsc_pkg::COORD_W-1:0]       out_value,
	output logic                              out_status,
	output logic                              out_last
);
	import bsc_pkg::*;

	localparam int DEPTH   = MAX_POINTS * MAX_DIM;
	localparam int MAW     = $clog2(DEPTH);
	localparam int NB      = MAX_DEGREE + 1;
	localparam int RIW     = $clog2(NB);
	localparam int CW      = $clog2(MAX_POINTS + 1);
	localparam int UW      = T_W + CW;
	localparam int RTW     = CW + 16;
	localparam int PW      = BASIS_W + RTW;
	localparam int HW      = CW + RIW + 1;
	localparam int DIM_LIM = (MAX_DIM < 4) ? MAX_DIM : 4;

	// effective configuration
	logic [RIW-1:0] deg_e;
	logic [CW-1:0]  cnt_e;
	logic [2:0]     dim_e;
	logic [CW-1:0]  spans;

	always_comb begin
		deg_e = (32'(cfg.degree) > MAX_DEGREE) ? RIW'(MAX_DEGREE) : RIW'(cfg.degree);
		cnt_e = (32'(cfg.point_count) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(cfg.point_count);
		if (cfg.point_dim == 3'd0)
			dim_e = 3'd1;
		else if (32'(cfg.point_dim) > DIM_LIM)
			dim_e = 3'(DIM_LIM);
		else
			dim_e = cfg.point_dim;
		spans = cnt_e - CW'(deg_e);
	end

	logic [COORD_W-1:0] mem [0:DEPTH-1];
	logic [COORD_W-1:0] rdata_s1;
	logic [BASIS_W-1:0] basis_q [0:NB-1];

	logic [T_W-1:0]     t_q;
	logic [UW-1:0]      u_q;
	logic [CW-1:0]      k_q;
	logic [RIW-1:0]     j_q, r_q;
	logic [DIM_W-1:0]   d_q;
	logic [BASIS_W-1:0] saved_q, full_q;
	logic [PW-1:0]      prod_q;
	logic [DEN_W-1:0]   den_q;
	logic [X_W-1:0]     x_q;
	logic [X_W+RECIP_W-1:0] prod2_q;

	// knot geometry of the current split
	logic [HW-1:0]      kr1;
	logic [CW-1:0]      hi, lo;
	logic [DEN_W-1:0]   den;
	logic [UW-1:0]      hiu;
	logic [RTW-1:0]     right;
	logic [BASIS_W-1:0] full;
	logic [CW:0]        kraw;

	always_comb begin
		kr1   = HW'(k_q) + HW'(r_q) + HW'(1);
		hi    = (kr1 > HW'(spans)) ? spans : CW'(kr1);
		if (kr1 <= HW'(j_q))
			lo = '0;
		else if (kr1 - HW'(j_q) > HW'(spans))
			lo = spans;
		else
			lo = CW'(kr1 - HW'(j_q));
		den   = DEN_W'(hi - lo);
		hiu   = UW'({hi, 16'd0});
		right = (hiu > u_q) ? RTW'(hiu - u_q) : '0;
		full  = basis_q[r_q];
		kraw  = u_q[UW-1:16];
	end

	// rounding division by the knot distance, reciprocal plus one correction
	logic [PW-1:0]      m_div;
	logic [X_W-1:0]     x_div;
	logic [Q_W-1:0]     q0, q;
	logic [REM_W-1:0]   rem;
	logic [BASIS_W-1:0] part;

	always_comb begin
		m_div = prod_q + (PW'(den_q) << 15);
		x_div = X_W'(m_div >> 16);
		q0    = Q_W'(prod2_q >> RECIP_SH);
		rem   = REM_W'(x_q) - REM_W'(q0) * REM_W'(den_q);
		q     = (rem >= REM_W'(den_q)) ? q0 + Q_W'(1) : q0;
		if (den_q == '0)
			part = '0;
		else if (q > Q_W'(full_q))
			part = full_q;
		else
			part = BASIS_W'(q);
	end

	// accumulate pipeline
	logic [HW-1:0]              pi;
	logic                       iv;
	logic [MAW-1:0]             raddr, waddr;
	logic                       rv_s1, pv_s2;
	logic [BASIS_W-1:0]         basis_s1;
	logic signed [ACC_W-1:0]    prod_s2;
	logic signed [ACC_W-1:0]    acc_q;

	always_comb begin
		pi    = HW'(k_q) + HW'(r_q);
		iv    = pi < HW'(MAX_POINTS);
		raddr = MAW'(pi) * MAW'(MAX_DIM) + MAW'(d_q);
		waddr = MAW'(in_point) * MAW'(MAX_DIM) + MAW'(in_coord);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr && (32'(in_point) < MAX_POINTS) && (32'(in_coord) < MAX_DIM))
			mem[waddr] <= in_value;
		if (cmd.acc_issue)
			rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.eval_start)
			t_q <= (in_t > ONE_Q16) ? ONE_Q16 : in_t;
		if (cmd.setup)
			u_q <= UW'(t_q) * UW'(spans);
		if (cmd.knot)
			k_q <= (kraw >= (CW+1)'(spans)) ? spans - CW'(1) : CW'(kraw);
		if (cmd.bas_mul) begin
			prod_q <= PW'(full) * PW'(right);
			den_q  <= den;
			full_q <= full;
		end
		if (cmd.bas_div) begin
			x_q     <= x_div;
			prod2_q <= (X_W+RECIP_W)'(x_div) * (X_W+RECIP_W)'(recip(den_q));
		end
		if (cmd.knot)
			basis_q[0] <= ONE_Q16;
		else if (cmd.bas_fix)
			basis_q[r_q] <= saved_q + part;
		else if (cmd.bas_tail)
			basis_q[j_q] <= saved_q;
		if (cmd.acc_issue)
			basis_s1 <= basis_q[r_q];
		if (rv_s1)
			prod_s2 <= ACC_W'($signed({1'b0, basis_s1})) * ACC_W'($signed(rdata_s1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q     <= '0;
			r_q     <= '0;
			d_q     <= '0;
			saved_q <= '0;
			rv_s1   <= 1'b0;
			pv_s2   <= 1'b0;
			acc_q   <= '0;
		end else begin
			rv_s1 <= cmd.acc_issue & iv;
			pv_s2 <= rv_s1;
			if (cmd.knot) begin
				j_q     <= RIW'(1);
				r_q     <= '0;
				saved_q <= '0;
			end else if (cmd.bas_fix) begin
				saved_q <= full_q - part;
				if (!st.r_last)
					r_q <= r_q + RIW'(1);
			end else if (cmd.bas_tail) begin
				saved_q <= '0;
				r_q     <= '0;
				if (!st.j_last)
					j_q <= j_q + RIW'(1);
			end else if (cmd.acc_issue) begin
				r_q <= st.acc_last ? '0 : r_q + RIW'(1);
			end
			if (cmd.setup)
				d_q <= '0;
			else if ((cmd.out_load || cmd.out_err) && !st.d_last)
				d_q <= d_q + DIM_W'(1);
			if (cmd.knot || cmd.out_load)
				acc_q <= '0;
			else if (pv_s2)
				acc_q <= acc_q + prod_s2;
		end
	end

	// round Q18.32 to Q16.16 and saturate
	logic signed [ACC_W-1:0] biased;
	logic signed [33:0]      sh;
	logic [COORD_W-1:0]      sat;

	always_comb begin
		biased = acc_q + ACC_W'(32768);
		sh     = 34'(biased >>> 16);
		if (!sh[33] && (sh[32] || sh[31]))
			sat = 32'h7FFF_FFFF;
		else if (sh[33] && !(sh[32] && sh[31]))
			sat = 32'h8000_0000;
		else
			sat = sh[31:0];
	end

	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load || cmd.out_err)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load || cmd.out_err) begin
			out_idx    <= d_q;
			out_value  <= cmd.out_load ? sat : '0;
			out_status <= cmd.out_err;
			out_last   <= st.d_last;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		st.err      = cnt_e <= CW'(deg_e) || 32'(deg_e) >= (1 << CW);
		st.deg_zero = deg_e == '0;
		st.r_last   = (RIW+1)'(r_q) + (RIW+1)'(1) == (RIW+1)'(j_q);
		st.j_last   = j_q == deg_e;
		st.acc_last = r_q == deg_e;
		st.d_last   = 3'(d_q) + 3'd1 == dim_e;
		st.out_free = !out_valid_q || out_ready;
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load || cmd.out_err) |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while full");

	a_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.bas_fix && den_q != '0) |-> (rem < (REM_W'(den_q) << 1)))
		else $error("reciprocal quotient off by more than one");

	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rv_s1 && !pv_s2))
		else $error("sum read before the pipeline drained");

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench of the B-spline curve evaluator: directed table, then random phases.
`timescale 1ns / 1ps
module tb;
	import bsc_pkg::*;

	// func field of a request
	typedef enum logic {FN_LOAD = 1'b0, FN_EVAL = 1'b1} func_e;
	// kinds of row in the directed table
	typedef enum logic [1:0] {ROW_LOAD, ROW_EVAL, ROW_CFG} row_kind_e;

	typedef struct {
		row_kind_e   kind;
		logic [5:0]  point;     // point number, or register index for ROW_CFG
		logic [1:0]  coord;
		logic [31:0] value;     // coordinate, or register value for ROW_CFG
		logic [16:0] t;
		bit          pinned;    // expected coordinates typed in below
		logic [31:0] pin_value;
		logic        pin_status;
	} dir_row_t;

	typedef struct {
		logic [1:0]  idx;
		logic [31:0] value;
		logic        status;
		logic        last;
	} coord_res_t;

	localparam int POINTS       = 64;
	localparam int DIMS         = 4;
	localparam int SETTLE       = 200;   // longer than the slowest evaluation
	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 44;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [63:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	bspline_curve_evaluator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Mirror of the block: control table, which entries were loaded, registers
	logic signed [31:0] ctrl_pts [POINTS*DIMS];
	bit                 ctrl_loaded [POINTS*DIMS];
	logic [2:0]         cur_degree = RST_DEGREE;
	logic [6:0]         cur_count  = RST_POINT_COUNT;
	logic [2:0]         cur_dim    = RST_POINT_DIM;

	coord_res_t curve_q[$];     // curve coordinates still owed by the block
	int         fail_count = 0;
	bit         no_gaps = 1'b0; // both sides run flat out while set
	bit         long_hold = 1'b0;
	bit         done = 1'b0;

	function automatic int eff_degree();
		return cur_degree;
	endfunction

	function automatic int eff_count();
		return (cur_count > POINTS) ? POINTS : cur_count;
	endfunction

	function automatic int eff_dim();
		if (cur_dim == 0)
			return 1;
		return (cur_dim > DIMS) ? DIMS : cur_dim;
	endfunction

	// Span in which t falls under the current settings
	function automatic int span_of(logic [16:0] tv);
		longint spans, t, k;
		t = (tv > ONE_Q16) ? ONE_Q16 : tv;
		spans = eff_count() - eff_degree();
		k = (t * spans) >>> 16;
		return (k >= spans) ? int'(spans - 1) : int'(k);
	endfunction

	// First table entry an evaluation at t would read before it was loaded, else -1
	function automatic int first_unloaded(logic [16:0] tv);
		int k;
		if (eff_count() <= eff_degree())
			return -1;
		k = span_of(tv);
		for (int r = 0; r <= eff_degree(); r++)
			for (int d = 0; d < eff_dim(); d++)
				if (!ctrl_loaded[(k + r) * DIMS + d])
					return (k + r) * DIMS + d;
		return -1;
	endfunction

	// Queue the coordinates of the curve point at t
	function automatic void predict_curve(logic [16:0] tv);
		longint deg, spans, t, u, k, hi, lo, den, right, full, part, saved, dd, q, v;
		longint basis [8];
		longint acc [DIMS];
		coord_res_t res;
		deg = eff_degree();
		if (eff_count() <= deg) begin
			for (int d = 0; d < eff_dim(); d++) begin
				res = '{idx: d, value: '0, status: 1'b1, last: (d + 1 == eff_dim())};
				curve_q.push_back(res);
			end
			return;
		end
		t = (tv > ONE_Q16) ? ONE_Q16 : tv;
		spans = eff_count() - deg;
		u = t * spans;
		k = span_of(tv);
		basis[0] = 65536;
		for (int j = 1; j <= deg; j++) begin
			saved = 0;
			for (int r = 0; r < j; r++) begin
				hi = k + 1 + r;
				hi = (hi > spans) ? spans : hi;
				lo = k + 1 + r - j;
				lo = (lo < 0) ? 0 : ((lo > spans) ? spans : lo);
				den = hi - lo;
				right = hi * 65536 - u;
				if (right < 0)
					right = 0;
				full = basis[r];
				part = 0;
				if (den > 0) begin
					dd = den << 16;
					q = (full * right + (dd >> 1)) / dd;
					part = (q > full) ? full : q;
				end
				basis[r] = saved + part;
				saved = full - part;
			end
			basis[j] = saved;
		end
		for (int d = 0; d < DIMS; d++)
			acc[d] = 0;
		for (int r = 0; r <= deg; r++)
			for (int d = 0; d < eff_dim(); d++)
				acc[d] += basis[r] * longint'(ctrl_pts[(k + r) * DIMS + d]);
		for (int d = 0; d < eff_dim(); d++) begin
			// round half up, then clamp to Q16.16
			v = (acc[d] + 32768) >>> 16;
			if (v > 64'sd2147483647)
				v = 64'sd2147483647;
			if (v < -64'sd2147483648)
				v = -64'sd2147483648;
			res = '{idx: d, value: v[31:0], status: 1'b0, last: (d + 1 == eff_dim())};
			curve_q.push_back(res);
		end
	endfunction

	// Offer one request after a random gap and hold it until taken
	task automatic send_request(func_e fn, logic [5:0] p, logic [1:0] c, logic [31:0] v,
			logic [16:0] tv);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= {7'b0, tv, v, c, p};
		s_tuser  <= fn;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// Wait for every owed coordinate, then let a pending load or evaluation drain
	task automatic drain();
		s_tvalid <= 1'b0;
		while (curve_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Setup and access cycle; the register takes the value at the access edge
	task automatic write_reg(logic [1:0] idx, logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_DEGREE:      cur_degree = v[2:0];
			REG_POINT_COUNT: cur_count  = v[6:0];
			REG_POINT_DIM:   cur_dim    = v[2:0];
			default: ;
		endcase
	endtask

	task automatic load_point(logic [5:0] p, logic [1:0] c, logic [31:0] v);
		send_request(FN_LOAD, p, c, v, 17'($urandom_range(17'h1FFFF)));
		ctrl_pts[p * DIMS + c]    = v;
		ctrl_loaded[p * DIMS + c] = 1'b1;
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return {{15{1'b0}}, 17'($urandom)};   // small positive
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [16:0] rand_t();
		case ($urandom_range(7))
			0: return '0;
			1: return ONE_Q16;
			2: return 17'($urandom_range(17'h1FFFF, ONE_Q16));
			default: return 17'($urandom_range(ONE_Q16));
		endcase
	endfunction

	function automatic dir_row_t mk_row(row_kind_e kind, logic [5:0] p, logic [1:0] c,
			logic [31:0] v, logic [16:0] tv, bit pin, logic [31:0] pv, logic ps);
		return '{kind: kind, point: p, coord: c, value: v, t: tv, pinned: pin,
			pin_value: pv, pin_status: ps};
	endfunction

	// Stimulus: directed table first, then random phases under varied settings
	initial begin
		dir_row_t dir_rows [$];
		int miss;
		logic [16:0] tv;
		int phase_deg [8]   = '{0, 7, 1, 7, 0, 4, 5, 2};
		int phase_cnt [8]   = '{1, 64, 2, 8, 64, 127, 5, 10};
		int phase_dim [8]   = '{1, 4, 2, 4, 3, 0, 7, 4};

		// corner points hold the extremes; t = 0 and t >= 1 land exactly on them
		for (int c = 0; c < 3; c++)
			dir_rows.push_back(mk_row(ROW_LOAD, 0, 2'(c), 32'h7FFF_FFFF, 0, 0, 0, 0));
		for (int c = 0; c < 3; c++)
			dir_rows.push_back(mk_row(ROW_LOAD, 3, 2'(c), 32'h8000_0000, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_LOAD, 1, 0, 32'h0001_0000, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_LOAD, 1, 1, 32'hFFFE_0000, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_LOAD, 1, 2, 32'h1234_5678, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_LOAD, 2, 0, 32'h5555_5555, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_LOAD, 2, 1, 32'hAAAA_AAAA, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_LOAD, 2, 2, 32'h0000_0000, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_LOAD, 63, 3, 32'hDEAD_BEEF, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_EVAL, 0, 0, 0, 17'd0, 1, 32'h7FFF_FFFF, 0));
		dir_rows.push_back(mk_row(ROW_EVAL, 0, 0, 0, ONE_Q16, 1, 32'h8000_0000, 0));
		dir_rows.push_back(mk_row(ROW_EVAL, 0, 0, 0, 17'h1FFFF, 1, 32'h8000_0000, 0));
		dir_rows.push_back(mk_row(ROW_EVAL, 0, 0, 0, 17'd32768, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_EVAL, 0, 0, 0, 17'd1, 0, 0, 0));
		// too few points for the degree: zero coordinates with error status
		dir_rows.push_back(mk_row(ROW_CFG, REG_DEGREE, 0, 7, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_CFG, REG_POINT_COUNT, 0, 1, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_EVAL, 0, 0, 0, 17'd40000, 1, 0, 1));
		dir_rows.push_back(mk_row(ROW_CFG, REG_POINT_DIM, 0, 4, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_EVAL, 0, 0, 0, 17'd0, 1, 0, 1));
		dir_rows.push_back(mk_row(ROW_CFG, REG_POINT_DIM, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_EVAL, 0, 0, 0, ONE_Q16, 1, 0, 1));
		dir_rows.push_back(mk_row(ROW_CFG, REG_POINT_DIM, 0, 7, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_EVAL, 0, 0, 0, 17'h1FFFF, 1, 0, 1));

		// hold reset, then release on a falling edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_LOAD: load_point(dir_rows[i].point, dir_rows[i].coord, dir_rows[i].value);
				ROW_EVAL: begin
					send_request(FN_EVAL, 0, 0, 0, dir_rows[i].t);
					if (dir_rows[i].pinned) begin
						for (int d = 0; d < eff_dim(); d++)
							curve_q.push_back('{idx: d, value: dir_rows[i].pin_value,
								status: dir_rows[i].pin_status, last: (d + 1 == eff_dim())});
					end else begin
						predict_curve(dir_rows[i].t);
					end
				end
				ROW_CFG: begin
					drain();
					write_reg(dir_rows[i].point[1:0], dir_rows[i].value);
				end
				default: ;
			endcase
		end

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			write_reg(REG_DEGREE, phase_deg[ph]);
			write_reg(REG_POINT_COUNT, phase_cnt[ph]);
			write_reg(REG_POINT_DIM, phase_dim[ph]);
			no_gaps   = (ph == 3);
			long_hold = (ph == 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(9) < 3) begin
					// refresh a point inside the curve, now and then anywhere
					load_point(6'(($urandom_range(3) == 0) ? $urandom_range(63)
						: $urandom_range(eff_count() - 1)), 2'($urandom_range(3)),
						rand_coord());
				end else begin
					tv = rand_t();
					miss = first_unloaded(tv);
					if (miss >= 0) begin
						// fill the hole first so the evaluation never reads junk
						load_point(6'(miss / DIMS), 2'(miss % DIMS), rand_coord());
					end else begin
						send_request(FN_EVAL, 6'($urandom), 2'($urandom), $urandom, tv);
						predict_curve(tv);
					end
				end
			end
		end
		no_gaps = 1'b0;
		drain();
		done = 1'b1;
	end

	// Result side: random stalls, one long hold-off when asked
	initial begin
		int stall;
		coord_res_t want;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				stall = HOLD_CYCLES;
			end else begin
				stall = no_gaps ? 0 : $urandom_range(19);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (curve_q.size() == 0) begin
				$error("unexpected result: idx %0d value %h", m_tdata[1:0], m_tdata[33:2]);
				fail_count++;
			end else begin
				want = curve_q.pop_front();
				if (m_tdata[1:0] !== want.idx) begin
					$error("out_coord_index expected %0d got %0d", want.idx, m_tdata[1:0]);
					fail_count++;
				end
				if (m_tdata[33:2] !== want.value) begin
					$error("out_coord_value expected %h got %h", want.value, m_tdata[33:2]);
					fail_count++;
				end
				if (m_tuser[0] !== want.status) begin
					$error("status expected %0d got %0d", want.status, m_tuser[0]);
					fail_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last expected %0d got %0d", want.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles without a handshake, and the verdict
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (!done && idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		if (done && fail_count == 0 && curve_q.size() == 0) begin
			$display("PASS bspline_curve_evaluator");
		end else begin
			if (!done)
				$error("watchdog: no handshake for %0d cycles", STALL_LIMIT);
			if (curve_q.size() != 0)
				$error("%0d expected coordinates never arrived", curve_q.size());
			$display("FAIL bspline_curve_evaluator");
		end
		$finish;
	end

endmodule
